@@ src/bq_pkg.sv @@
package bq_pkg;

    localparam int DEF_SAMPLE_BITS = 24;
    localparam int DEF_COEF_BITS   = 32;
    localparam int DELAY_BITS      = 40;
    localparam int DELAY_FRAC      = 8;
    localparam int COEF_INT_BITS   = 4;
    localparam int KEEP_BITS       = DELAY_FRAC + COEF_INT_BITS;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [CFG_INDEX_BITS-1:0] REG_B0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B1 = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_B2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_A1 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_A2 = 3'd4;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MULX,
        S_YSUM,
        S_YRND,
        S_LOADY,
        S_MULY,
        S_UPD1,
        S_UPD2,
        S_OUT
    } state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } mul_ctrl_t;

endpackage

@@ src/bq_smul.sv @@
module bq_smul
    import bq_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = DEF_COEF_BITS
)
(
    input  logic                                     clk,
    input  mul_ctrl_t                                ctrl,
    input  logic signed [SAMPLE_BITS-1:0]            mcand,
    input  logic [COEF_BITS-1:0]                     coef,
    output logic signed [SAMPLE_BITS+KEEP_BITS-1:0]  prod
);

    logic signed [SAMPLE_BITS-1:0] mcand_reg;
    logic [COEF_BITS-1:0]          coef_reg;
    logic signed [SAMPLE_BITS:0]   acc_reg;
    logic [KEEP_BITS-1:0]          lo_reg;
    logic signed [SAMPLE_BITS+1:0] addend;
    logic signed [SAMPLE_BITS+1:0] sum;

    always_comb
    begin
        addend = '0;
        if (coef_reg[0])
        begin
            if (ctrl.last)
                addend = -((SAMPLE_BITS+2)'(mcand_reg));
            else
                addend = (SAMPLE_BITS+2)'(mcand_reg);
        end
        sum = (SAMPLE_BITS+2)'(acc_reg) + addend;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mcand_reg <= mcand;
            coef_reg  <= coef;
            acc_reg   <= '0;
            lo_reg    <= '0;
        end
        else if (ctrl.step)
        begin
            coef_reg <= coef_reg >> 1;
            acc_reg  <= $signed(sum[SAMPLE_BITS+1:1]);
            lo_reg   <= {sum[0], lo_reg[KEEP_BITS-1:1]};
        end
    end

    assign prod = $signed({acc_reg[SAMPLE_BITS-1:0], lo_reg});

endmodule

@@ src/biquad_iir_filter.sv @@
// Biquad IIR filter, transposed direct form II, signed fixed point.
// Input channel: in_valid/in_stall with sample_in and block_end; a word is
// taken when in_valid is high and in_stall low. in_stall is low only while
// the block is idle.
// Output channel: out_valid/out_stall with sample_out and block_end_out, one
// output word per input word, in order, held in an output register.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 b0, 1 b1, 2 b2, 3 a1,
// 4 a2) and cfg_data; cfg_ready is always high, other indexes are dropped.
// Write coefficients only while the filter is idle.
// Timing: three bit-serial multipliers take one coefficient bit per cycle;
// x*b0, x*b1, x*b2 run in one pass, y*a1, y*a2 in a second; in between y is
// summed, rounded and loaded; after the second pass both delays are updated
// and the result goes to the output register; only then is a new word taken.
// A stalled output holds its word; a finished result waits in the last state
// until the output register is free.
// Reset clears both delays, sets b0 to 1.0 and the other coefficients to 0,
// and empties the output register.
module biquad_iir_filter
    import bq_pkg::*;
#(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
    parameter int COEF_BITS   = DEF_COEF_BITS
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic                          block_end,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          block_end_out,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data
);

    localparam int PW    = SAMPLE_BITS + KEEP_BITS;
    localparam int ACCW  = ((PW > DELAY_BITS) ? PW : DELAY_BITS) + 2;
    localparam int QW    = ACCW - DELAY_FRAC;
    localparam int CW    = ((PW + 1 > DELAY_BITS) ? PW + 1 : DELAY_BITS) + 1;
    localparam int CNT_W = $clog2(COEF_BITS);

    localparam logic [COEF_BITS-1:0] COEF_ONE =
        {{(COEF_INT_BITS-1){1'b0}}, 1'b1, {(COEF_BITS-COEF_INT_BITS){1'b0}}};
    localparam logic signed [ACCW-1:0] HALF_LSB = ACCW'(1) << (DELAY_FRAC - 1);
    localparam logic signed [QW-1:0] Y_MAX =
        {{(QW-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [QW-1:0] Y_MIN = ~Y_MAX;

    function automatic logic signed [DELAY_BITS-1:0] sat_delay(
        input logic signed [CW-1:0] v
    );
        logic signed [CW-1:0] hi;
        logic signed [CW-1:0] lo;
        hi = {{(CW-DELAY_BITS+1){1'b0}}, {(DELAY_BITS-1){1'b1}}};
        lo = ~hi;
        if (v > hi)
            sat_delay = hi[DELAY_BITS-1:0];
        else if (v < lo)
            sat_delay = lo[DELAY_BITS-1:0];
        else
            sat_delay = v[DELAY_BITS-1:0];
    endfunction

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]              cnt_reg;
    logic [CNT_W-1:0]              cnt_next;
    logic [COEF_BITS-1:0]          b0_reg;
    logic [COEF_BITS-1:0]          b1_reg;
    logic [COEF_BITS-1:0]          b2_reg;
    logic [COEF_BITS-1:0]          a1_reg;
    logic [COEF_BITS-1:0]          a2_reg;
    logic signed [DELAY_BITS-1:0]  d1_reg;
    logic signed [DELAY_BITS-1:0]  d2_reg;
    logic signed [PW-1:0]          m1_reg;
    logic signed [PW:0]            t1_reg;
    logic signed [ACCW-1:0]        sum_reg;
    logic signed [SAMPLE_BITS-1:0] y_reg;
    logic                          be_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          block_end_out_reg;

    logic                          in_take;
    logic                          out_load;
    logic                          last_bit;
    mul_ctrl_t                     ctrl01;
    mul_ctrl_t                     ctrl2;
    logic signed [SAMPLE_BITS-1:0] mcand01;
    logic [COEF_BITS-1:0]          coef0;
    logic [COEF_BITS-1:0]          coef1;
    logic signed [PW-1:0]          prod0;
    logic signed [PW-1:0]          prod1;
    logic signed [PW-1:0]          prod2;
    logic signed [ACCW-1:0]        rnd;
    logic signed [QW-1:0]          q;
    logic signed [SAMPLE_BITS-1:0] y_sat;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_stall   = 1'b1;
        in_take    = 1'b0;
        out_load   = 1'b0;
        last_bit   = (cnt_reg == CNT_W'(COEF_BITS - 1));
        ctrl01     = '0;
        ctrl2      = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    in_take     = 1'b1;
                    ctrl01.load = 1'b1;
                    ctrl2.load  = 1'b1;
                    cnt_next    = '0;
                    state_next  = S_MULX;
                end
            end
            S_MULX:
            begin
                ctrl01.step = 1'b1;
                ctrl01.last = last_bit;
                ctrl2.step  = 1'b1;
                ctrl2.last  = last_bit;
                cnt_next    = cnt_reg + 1'b1;
                if (last_bit)
                    state_next = S_YSUM;
            end
            S_YSUM:
                state_next = S_YRND;
            S_YRND:
                state_next = S_LOADY;
            S_LOADY:
            begin
                ctrl01.load = 1'b1;
                cnt_next    = '0;
                state_next  = S_MULY;
            end
            S_MULY:
            begin
                ctrl01.step = 1'b1;
                ctrl01.last = last_bit;
                cnt_next    = cnt_reg + 1'b1;
                if (last_bit)
                    state_next = S_UPD1;
            end
            S_UPD1:
                state_next = S_UPD2;
            S_UPD2:
                state_next = S_OUT;
            S_OUT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    assign mcand01 = (state_reg == S_IDLE) ? sample_in : y_reg;
    assign coef0   = (state_reg == S_IDLE) ? b0_reg : a1_reg;
    assign coef1   = (state_reg == S_IDLE) ? b1_reg : a2_reg;

    bq_smul #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mul0 (
        .clk   (clk),
        .ctrl  (ctrl01),
        .mcand (mcand01),
        .coef  (coef0),
        .prod  (prod0)
    );

    bq_smul #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mul1 (
        .clk   (clk),
        .ctrl  (ctrl01),
        .mcand (mcand01),
        .coef  (coef1),
        .prod  (prod1)
    );

    bq_smul #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_mul2 (
        .clk   (clk),
        .ctrl  (ctrl2),
        .mcand (sample_in),
        .coef  (b2_reg),
        .prod  (prod2)
    );

    always_comb
    begin
        rnd = sum_reg + HALF_LSB;
        q   = $signed(rnd[ACCW-1:DELAY_FRAC]);
        if (q > Y_MAX)
            y_sat = Y_MAX[SAMPLE_BITS-1:0];
        else if (q < Y_MIN)
            y_sat = Y_MIN[SAMPLE_BITS-1:0];
        else
            y_sat = q[SAMPLE_BITS-1:0];
    end

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_reg <= COEF_ONE;
            b1_reg <= '0;
            b2_reg <= '0;
            a1_reg <= '0;
            a2_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_B0:  b0_reg <= cfg_data;
                REG_B1:  b1_reg <= cfg_data;
                REG_B2:  b2_reg <= cfg_data;
                REG_A1:  a1_reg <= cfg_data;
                REG_A2:  a2_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (state_reg == S_UPD2)
        begin
            d1_reg <= sat_delay(CW'(t1_reg) + CW'(d2_reg));
            d2_reg <= sat_delay(CW'(prod2) - CW'(prod1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
            be_reg <= block_end;
        if (state_reg == S_YSUM)
        begin
            sum_reg <= ACCW'(prod0) + ACCW'(d1_reg);
            m1_reg  <= prod1;
        end
        if (state_reg == S_YRND)
            y_reg <= y_sat;
        if (state_reg == S_UPD1)
            t1_reg <= (PW+1)'(m1_reg) - (PW+1)'(prod0);
        if (out_load)
        begin
            sample_out_reg    <= y_reg;
            block_end_out_reg <= be_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

    a_take_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == S_MULX && cnt_reg == '0))
        else $error("accepted word did not start the multiply pass");

    a_out_from_final: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_OUT)
        else $error("output word loaded outside the final state");

    a_delay_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_UPD2) |=> ($stable(d1_reg) && $stable(d2_reg)))
        else $error("delay state changed outside the update step");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> $stable(sample_out_reg))
        else $error("stalled output word overwritten");

endmodule

@@ tb/tb.sv @@
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import bq_pkg::*;

    localparam int SAMPLE_W = DEF_SAMPLE_BITS;
    localparam int COEF_W = DEF_COEF_BITS;
    localparam int COEF_FRAC = COEF_W - COEF_INT_BITS;
    localparam int PROD_SHIFT = COEF_FRAC - DELAY_FRAC;
    localparam longint UNITY = longint'(1) <<< COEF_FRAC;
    localparam longint PROD_CAP = longint'(1) <<< 60;
    localparam int unsigned A2_SPAN = 32'((UNITY * 95) / 100);
    localparam int unsigned B_SPAN = 32'(2 * UNITY);
    localparam int PHASES = 15;
    localparam int PHASE_WORDS = 110;
    localparam int IDLE_LIMIT = 4000;
    localparam int TAIL = 2 * COEF_W + 8;
    localparam int SHOW_MAX = 10;

    localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [SAMPLE_W-1:0] SMP_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic [SAMPLE_W-1:0] SMP_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } audio_word_t;

    logic clk;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic block_end = 1'b0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic block_end_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COEF_W-1:0] cfg_data = '0;

    audio_word_t sample_queue[$];
    audio_word_t due_outputs[$];
    logic signed [COEF_W-1:0] coef_q [0:REG_A2];
    longint dly_one;
    longint dly_two;

    bit quiet = 1'b0;
    int send_pct = 30;
    int stall_pct = 30;
    int gap_left;
    int stall_left;
    int idle_cycles = 0;
    int words_sent = 0;
    int words_checked = 0;
    int coef_sets = 0;
    int out_clips = 0;
    int delay_clips = 0;
    int fault_count = 0;
    int shown = 0;

    biquad_iir_filter #(
        .SAMPLE_BITS(SAMPLE_W),
        .COEF_BITS  (COEF_W)
    ) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .sample_in    (sample_in),
        .block_end    (block_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .sample_out   (sample_out),
        .block_end_out(block_end_out),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic longint scale_mul(longint x, longint c);
        longint p;
        p = (x * c) >>> PROD_SHIFT;
        if (p > PROD_CAP)
            p = PROD_CAP;
        else if (p < -PROD_CAP)
            p = -PROD_CAP;
        return p;
    endfunction

    function automatic longint clip(longint v, int bits);
        longint hi;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        if (v > hi)
            return hi;
        if (v < -hi - 1)
            return -hi - 1;
        return v;
    endfunction

    function automatic longint pick_corner();
        case ($urandom_range(0, 4))
            0: return longint'(signed'(COEF_MAX));
            1: return longint'(signed'(COEF_MIN));
            2: return 0;
            3: return UNITY;
            default: return -UNITY;
        endcase
    endfunction

    task automatic filter_step(input logic signed [SAMPLE_W-1:0] x_in, input logic last);
        longint x;
        longint acc;
        longint y_raw;
        longint y;
        longint d1;
        longint d2;
        audio_word_t w;
        x = x_in;
        acc = scale_mul(x, coef_q[REG_B0]) + dly_one;
        y_raw = (acc + (longint'(1) <<< (DELAY_FRAC - 1))) >>> DELAY_FRAC;
        y = clip(y_raw, SAMPLE_W);
        d1 = scale_mul(x, coef_q[REG_B1]) - scale_mul(y, coef_q[REG_A1]) + dly_two;
        d2 = scale_mul(x, coef_q[REG_B2]) - scale_mul(y, coef_q[REG_A2]);
        dly_one = clip(d1, DELAY_BITS);
        dly_two = clip(d2, DELAY_BITS);
        if (y != y_raw)
            out_clips++;
        if (dly_one != d1 || dly_two != d2)
            delay_clips++;
        w.sample = y[SAMPLE_W-1:0];
        w.last = last;
        due_outputs.push_back(w);
    endtask

    task automatic push_word(input logic [SAMPLE_W-1:0] x, input logic last);
        audio_word_t w;
        w.sample = x;
        w.last = last;
        sample_queue.push_back(w);
    endtask

    task automatic push_edge_words();
        push_word(SMP_MAX, 1'b0);
        push_word(SMP_MAX, 1'b0);
        push_word(SMP_MIN, 1'b1);
        push_word(SMP_MIN, 1'b0);
        push_word('0, 1'b0);
        push_word('1, 1'b1);
        push_word(SAMPLE_W'(1), 1'b0);
        push_word(SMP_MAX, 1'b1);
    endtask

    task automatic settle();
        do
            @(negedge clk);
        while (sample_queue.size() != 0 || in_valid || due_outputs.size() != 0);
    endtask

    task automatic write_coef(input logic [CFG_INDEX_BITS-1:0] idx, input logic [COEF_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic load_coefs(input longint b0, input longint b1, input longint b2,
                              input longint a1, input longint a2);
        write_coef(REG_B0, COEF_W'(b0));
        write_coef(REG_B1, COEF_W'(b1));
        write_coef(REG_B2, COEF_W'(b2));
        write_coef(REG_A1, COEF_W'(a1));
        write_coef(REG_A2, COEF_W'(a2));
        coef_sets++;
    endtask

    // mirror the coefficient registers
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_q[REG_B0] <= COEF_W'(UNITY);
            coef_q[REG_B1] <= '0;
            coef_q[REG_B2] <= '0;
            coef_q[REG_A1] <= '0;
            coef_q[REG_A2] <= '0;
        end
        else if (cfg_valid && cfg_ready && cfg_index <= REG_A2)
        begin
            coef_q[cfg_index] <= cfg_data;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : feed
        audio_word_t nxt;
        int gap;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            sample_in <= '0;
            block_end <= 1'b0;
            gap_left <= 0;
            dly_one = 0;
            dly_two = 0;
        end
        else
        begin
            gap = gap_left;
            if (in_valid && !in_stall)
            begin
                filter_step(sample_in, block_end);
                words_sent++;
                gap = 0;
                if (!quiet && $urandom_range(0, 99) < send_pct)
                    gap = $urandom_range(1, 4);
            end
            // hold a stalled word
            if (!(in_valid && in_stall))
            begin
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    gap_left <= gap - 1;
                end
                else if (sample_queue.size() > 0)
                begin
                    nxt = sample_queue.pop_front();
                    in_valid <= 1'b1;
                    sample_in <= nxt.sample;
                    block_end <= nxt.last;
                    gap_left <= 0;
                end
                else
                begin
                    in_valid <= 1'b0;
                    gap_left <= 0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drain
        audio_word_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (due_outputs.size() == 0)
                begin
                    fault_count++;
                    if (shown < SHOW_MAX)
                    begin
                        shown++;
                        $display("unexpected word: sample %0d last %0b", sample_out, block_end_out);
                    end
                end
                else
                begin
                    want = due_outputs.pop_front();
                    words_checked++;
                    if (sample_out !== want.sample || block_end_out !== want.last)
                    begin
                        fault_count++;
                        if (shown < SHOW_MAX)
                        begin
                            shown++;
                            $display("word %0d: sample exp %0d got %0d, last exp %0b got %0b",
                                     words_checked, want.sample, sample_out,
                                     want.last, block_end_out);
                        end
                    end
                end
            end
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left <= stall_left - 1;
            end
            else if (!quiet && $urandom_range(0, 99) < stall_pct)
            begin
                out_stall <= 1'b1;
                stall_left <= $urandom_range(0, 3);
            end
            else
            begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("watchdog: %0d cycles without a transfer", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stim
        int n;
        int k;
        int r;
        int kind;
        longint cb0;
        longint cb1;
        longint cb2;
        longint ca1;
        longint ca2;
        longint span;
        logic signed [SAMPLE_W-1:0] x;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset coefficients pass the input through
        push_edge_words();
        settle();

        load_coefs(signed'(COEF_MAX), signed'(COEF_MIN), signed'(COEF_MAX),
                   signed'(COEF_MIN), signed'(COEF_MAX));
        for (k = 1; k <= 3; k++)
            write_coef(REG_A2 + CFG_INDEX_BITS'(k), $urandom());
        push_edge_words();
        settle();

        load_coefs(signed'(COEF_MIN), signed'(COEF_MIN), signed'(COEF_MIN),
                   signed'(COEF_MIN), signed'(COEF_MIN));
        push_edge_words();
        settle();

        for (n = 0; n < PHASES; n++)
        begin
            quiet = (n == PHASES - 1) || (n == PHASES / 2);
            send_pct = $urandom_range(10, 60);
            stall_pct = $urandom_range(10, 60);
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                cb0 = $urandom();
                cb1 = $urandom();
                cb2 = $urandom();
                ca1 = $urandom();
                ca2 = $urandom();
            end
            else if (kind == 1)
            begin
                cb0 = pick_corner();
                cb1 = pick_corner();
                cb2 = pick_corner();
                ca1 = pick_corner();
                ca2 = pick_corner();
            end
            else
            begin
                // stable poles, gain up to two
                ca2 = longint'($urandom_range(0, 2 * A2_SPAN)) - longint'(A2_SPAN);
                span = ((UNITY + ca2) * 95) / 100;
                ca1 = longint'($urandom_range(0, 32'(2 * span))) - span;
                cb0 = longint'($urandom_range(0, 2 * B_SPAN)) - longint'(B_SPAN);
                cb1 = longint'($urandom_range(0, 2 * B_SPAN)) - longint'(B_SPAN);
                cb2 = longint'($urandom_range(0, 2 * B_SPAN)) - longint'(B_SPAN);
            end
            load_coefs(cb0, cb1, cb2, ca1, ca2);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    x = SMP_MAX;
                else if (r < 8)
                    x = SMP_MIN;
                else if (r < 20)
                    x = '0;
                else if (r < 50)
                    x = SAMPLE_W'($urandom_range(0, 8191)) - SAMPLE_W'(4096);
                else
                    x = SAMPLE_W'($urandom());
                push_word(x, $urandom_range(0, 9) == 0);
            end
            settle();
        end

        repeat (TAIL) @(posedge clk);
        fault_count += due_outputs.size();

        $display("filtered %0d input words, checked %0d outputs, %0d coefficient sets",
                 words_sent, words_checked, coef_sets);
        $display("output clips %0d, delay clips %0d, bad words %0d",
                 out_clips, delay_clips, fault_count);
        if (fault_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ files.f @@
src/bq_pkg.sv
src/bq_smul.sv
src/biquad_iir_filter.sv
tb/tb.sv
